[design/ilid_pkg.sv]
// Shared types and field widths for the indexed list block.
// No dependencies; imported by every module of the block.
package ilid_pkg;

   localparam int CMD_W    = 3;
   localparam int POS_W    = 5;
   localparam int VAL_W    = 32;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 4;
   localparam int COUNT_W  = 5;

   typedef enum logic [CMD_W-1:0] {
      OP_APPEND = 3'd0,
      OP_INSERT = 3'd1,
      OP_DELETE = 3'd2,
      OP_READ   = 3'd3,
      OP_CLEAR  = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_BAD_POS = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   // Broadcast to every cell of the row in the cycle of a transfer.
   typedef struct packed {
      logic ins_en;
      logic del_en;
   } cell_ctl_type;

   typedef struct packed {
      status_type status;
      logic       read_ok;
   } resp_type;

endpackage

[design/ilid_cell.sv]
// One storage cell of the list row: holds one word and trades it with its neighbors.
// Depends on ilid_pkg for the cell control struct.
module ilid_cell #(
   parameter int IDX    = 0,
   parameter int WORD_W = 32,
   parameter int PW     = 5
) (
   input  logic                 clock,
   input  ilid_pkg::cell_ctl_type ctl,
   input  logic [PW-1:0]        pos,
   input  logic [WORD_W-1:0]    word,
   input  logic [WORD_W-1:0]    left_value,
   input  logic [WORD_W-1:0]    right_value,
   output logic [WORD_W-1:0]    value,
   output logic [WORD_W-1:0]    rd_value
);
   import ilid_pkg::*;

   localparam logic [PW-1:0] MY_IDX = PW'(IDX);

   logic [WORD_W-1:0] value_ff;
   logic [WORD_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (ctl.ins_en) begin
         // shift up above the target, take the new word at it
         if (MY_IDX > pos) begin
            value_in = left_value;
         end else if (MY_IDX == pos) begin
            value_in = word;
         end
      end else if (ctl.del_en) begin
         if (MY_IDX >= pos) begin
            value_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value    = value_ff;
   assign rd_value = (MY_IDX == pos) ? value_ff : '0;

endmodule

[design/ilid_ctrl.sv]
// Command decode for the list: range and full checks, next count, cell controls.
// Depends on ilid_pkg for op codes, status codes and control structs.
module ilid_ctrl #(
   parameter int DEPTH = 16,
   parameter int CNT_W = 5,
   parameter int PW    = 5
) (
   input  logic [ilid_pkg::CMD_W-1:0] cmd,
   input  logic [ilid_pkg::POS_W-1:0] position,
   input  logic [CNT_W-1:0]           count,
   output ilid_pkg::cell_ctl_type     ctl,
   output logic [PW-1:0]              pos,
   output logic [PW-1:0]              where,
   output logic [CNT_W-1:0]           count_next,
   output ilid_pkg::resp_type         resp
);
   import ilid_pkg::*;

   logic [PW-1:0] pos_ext;
   logic [PW-1:0] cnt_ext;
   logic          full;

   assign pos_ext = PW'(position);
   assign cnt_ext = PW'(count);
   assign full    = (count == CNT_W'(DEPTH));

   always_comb begin
      ctl          = '0;
      pos          = pos_ext;
      where        = '0;
      count_next   = count;
      resp.status  = ST_OK;
      resp.read_ok = 1'b0;
      case (op_type'(cmd))
         OP_APPEND: begin
            pos = cnt_ext;
            if (full) begin
               resp.status = ST_FULL;
            end else begin
               ctl.ins_en = 1'b1;
               where      = cnt_ext;
               count_next = count + 1'b1;
            end
         end
         OP_INSERT: begin
            if (pos_ext > cnt_ext) begin
               resp.status = ST_BAD_POS;
            end else if (full) begin
               resp.status = ST_FULL;
            end else begin
               ctl.ins_en = 1'b1;
               where      = pos_ext;
               count_next = count + 1'b1;
            end
         end
         OP_DELETE: begin
            if (pos_ext >= cnt_ext) begin
               resp.status = ST_BAD_POS;
            end else begin
               ctl.del_en = 1'b1;
               where      = pos_ext;
               count_next = count - 1'b1;
            end
         end
         OP_READ: begin
            if (pos_ext >= cnt_ext) begin
               resp.status = ST_BAD_POS;
            end else begin
               resp.read_ok = 1'b1;
               where        = pos_ext;
            end
         end
         OP_CLEAR: begin
            count_next = '0;
         end
         default: begin
         end
      endcase
   end

endmodule

[design/indexed_list_insert_delete.sv]
// Ordered list of up to DEPTH words held in a row of cells that shift in parallel.
// Uses ilid_pkg, ilid_ctrl and ilid_cell.
//
// A command is taken at every clock edge where start is high; busy stays low, so a new
// command may follow in each cycle. A command's result appears in the cycle after its
// transfer, for one cycle, with rsp_valid high: one item per cycle. For an insert or delete,
// the cells above the target (at and above it for a delete) take a neighbor's word in the
// same cycle, and a read selects the addressed cell directly. There is no back-pressure on
// the result side. Words above the held count are never reported, so the row needs no
// clearing after reset; only the count and the result strobe are reset to zero.
module indexed_list_insert_delete #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [ilid_pkg::CMD_W-1:0]        req_cmd,
   input  logic [ilid_pkg::POS_W-1:0]        req_position,
   input  logic [ilid_pkg::VAL_W-1:0]        req_item_value,
   output logic                              rsp_valid,
   output logic [ilid_pkg::STATUS_W-1:0]     rsp_status,
   output logic [ilid_pkg::INDEX_W-1:0]      rsp_index_out,
   output logic [ilid_pkg::VAL_W-1:0]        rsp_read_value,
   output logic [ilid_pkg::COUNT_W-1:0]      rsp_count
);
   import ilid_pkg::*;

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int PW     = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int WORD_W = (DATA_WIDTH < VAL_W) ? DATA_WIDTH : VAL_W;

   logic                  accept;
   cell_ctl_type          ctl;
   cell_ctl_type          cell_ctl;
   logic [PW-1:0]         pos;
   logic [PW-1:0]         where;
   logic [CNT_W-1:0]      count_next;
   resp_type              resp;
   logic [WORD_W-1:0]     word;
   logic [WORD_W-1:0]     cell_value [DEPTH];
   logic [WORD_W-1:0]     cell_rd    [DEPTH];
   logic [WORD_W-1:0]     rd_sel;

   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [INDEX_W-1:0]    rsp_index_ff;
   logic [VAL_W-1:0]      rsp_read_ff;
   logic [VAL_W-1:0]      rsp_read_in;
   logic [COUNT_W-1:0]    rsp_count_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign word   = req_item_value[WORD_W-1:0];

   ilid_ctrl #(
      .DEPTH (DEPTH),
      .CNT_W (CNT_W),
      .PW    (PW)
   ) u_ctrl (
      .cmd        (req_cmd),
      .position   (req_position),
      .count      (count_ff),
      .ctl        (ctl),
      .pos        (pos),
      .where      (where),
      .count_next (count_next),
      .resp       (resp)
   );

   // drop the shift controls when no transfer happens
   assign cell_ctl = accept ? ctl : '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WORD_W-1:0] left_value;
      logic [WORD_W-1:0] right_value;
      if (i == 0) begin : g_first
         assign left_value = word;
      end else begin : g_inner_l
         assign left_value = cell_value[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_value = cell_value[i];
      end else begin : g_inner_r
         assign right_value = cell_value[i+1];
      end
      ilid_cell #(
         .IDX    (i),
         .WORD_W (WORD_W),
         .PW     (PW)
      ) u_cell (
         .clock       (clock),
         .ctl         (cell_ctl),
         .pos         (pos),
         .word        (word),
         .left_value  (left_value),
         .right_value (right_value),
         .value       (cell_value[i]),
         .rd_value    (cell_rd[i])
      );
   end

   // only the addressed cell drives a nonzero word
   always_comb begin
      rd_sel = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_sel = rd_sel | cell_rd[i];
      end
   end

   assign count_in    = accept ? count_next : count_ff;
   assign rsp_read_in = resp.read_ok ? VAL_W'(rd_sel) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= resp.status;
         rsp_index_ff  <= where[INDEX_W-1:0];
         rsp_read_ff   <= rsp_read_in;
         rsp_count_ff  <= COUNT_W'(count_next);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_index_out  = rsp_index_ff;
   assign rsp_read_value = rsp_read_ff;
   assign rsp_count      = rsp_count_ff;

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (!reset && accept) |=> rsp_valid)
      else $error("command transfer without a result in the next cycle");

   a_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (!reset && !accept) |=> !rsp_valid)
      else $error("result strobe without a command transfer");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("held count exceeds capacity");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> count_ff == CNT_W'(DEPTH))
      else $error("full status reported while list is not full");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (!reset && !accept) |=> $stable(count_ff))
      else $error("count changed without a command transfer");

endmodule

[verif/list_checker.sv]
`timescale 1ns / 100ps
// Checker for the indexed list block: follows the command and result transfers,
// keeps its own copy of the list and compares every result field in order.
// Depends on ilid_pkg for the command and status codes and the field widths.
module list_checker
   import ilid_pkg::*;
#(
   parameter int LIST_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [POS_W-1:0]    req_position,
   input  logic [VAL_W-1:0]    req_item_value,
   input  logic                rsp_valid,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic [INDEX_W-1:0]  rsp_index_out,
   input  logic [VAL_W-1:0]    rsp_read_value,
   input  logic [COUNT_W-1:0]  rsp_count,
   output int                  error_count,
   output int                  pending_count
);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  index;
      logic [VAL_W-1:0]    data;
      logic [COUNT_W-1:0]  count;
   } list_result_t;

   logic [VAL_W-1:0] held_words [LIST_DEPTH];
   int               held_count = 0;
   list_result_t     expected_results [$];
   int               mismatches = 0;

   initial begin
      error_count = 0;
      pending_count = 0;
   end

   // Apply one command to the local list and work out the result it reports.
   task automatic apply_list_op(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                input logic [VAL_W-1:0] word, output list_result_t res);
      int p;
      p = int'(pos);
      res = '0;
      res.status = ST_OK;
      case (cmd)
         OP_APPEND: begin
            if (held_count >= LIST_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               held_words[held_count] = word;
               res.index = INDEX_W'(held_count);
               held_count++;
            end
         end
         OP_INSERT: begin
            // the position check takes priority over the full check
            if (p > held_count) begin
               res.status = ST_BAD_POS;
            end else if (held_count >= LIST_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               for (int i = LIST_DEPTH - 1; i > 0; i--) begin
                  if (i > p && i <= held_count) held_words[i] = held_words[i-1];
               end
               held_words[p] = word;
               res.index = INDEX_W'(p);
               held_count++;
            end
         end
         OP_DELETE: begin
            if (p >= held_count) begin
               res.status = ST_BAD_POS;
            end else begin
               for (int i = 0; i < LIST_DEPTH - 1; i++) begin
                  if (i >= p && i + 1 < held_count) held_words[i] = held_words[i+1];
               end
               res.index = INDEX_W'(p);
               held_count--;
            end
         end
         OP_READ: begin
            if (p >= held_count) begin
               res.status = ST_BAD_POS;
            end else begin
               res.data = held_words[p];
               res.index = INDEX_W'(p);
            end
         end
         OP_CLEAR: begin
            held_count = 0;
         end
         default: begin
            // unused codes leave everything alone
         end
      endcase
      res.count = COUNT_W'(held_count);
   endtask

   task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                              input logic [VAL_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      list_result_t want;
      list_result_t fresh;
      if (reset) begin
         held_count = 0;
         expected_results.delete();
      end else begin
         // a result belongs to an earlier transfer, so retire it before adding the new one
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result: status %0d index %0d data 0x%0h count %0d",
                        $time, rsp_status, rsp_index_out, rsp_read_value, rsp_count);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               check_field("status", VAL_W'(want.status), VAL_W'(rsp_status));
               check_field("index_out", VAL_W'(want.index), VAL_W'(rsp_index_out));
               check_field("read_value", want.data, rsp_read_value);
               check_field("count", VAL_W'(want.count), VAL_W'(rsp_count));
            end
         end
         if (start && !busy) begin
            apply_list_op(req_cmd, req_position, req_item_value, fresh);
            expected_results.push_back(fresh);
         end
      end
      error_count <= mismatches;
      pending_count <= expected_results.size();
   end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// Top of the indexed list testbench: clock, reset, command stimulus and the verdict.
// Depends on ilid_pkg, indexed_list_insert_delete and list_checker.
module testbench;
   import ilid_pkg::*;

   localparam int RANDOM_ITEMS = 1100;
   localparam int IDLE_LIMIT   = 200;
   localparam int MODE_FILL    = 0;
   localparam int MODE_DRAIN   = 1;
   localparam int MODE_MIXED   = 2;
   localparam logic [CMD_W-1:0] FIRST_UNUSED_OP = 3'd5;
   localparam logic [CMD_W-1:0] MID_UNUSED_OP   = 3'd6;
   localparam logic [CMD_W-1:0] LAST_UNUSED_OP  = 3'd7;

   logic                clock;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [CMD_W-1:0]    req_cmd = '0;
   logic [POS_W-1:0]    req_position = '0;
   logic [VAL_W-1:0]    req_item_value = '0;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [INDEX_W-1:0]  rsp_index_out;
   logic [VAL_W-1:0]    rsp_read_value;
   logic [COUNT_W-1:0]  rsp_count;
   int                  list_errors;
   int                  results_pending;
   int                  idle_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   indexed_list_insert_delete DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_position   (req_position),
      .req_item_value (req_item_value),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_index_out  (rsp_index_out),
      .rsp_read_value (rsp_read_value),
      .rsp_count      (rsp_count)
   );

   list_checker LIST_CHECK (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_position   (req_position),
      .req_item_value (req_item_value),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_index_out  (rsp_index_out),
      .rsp_read_value (rsp_read_value),
      .rsp_count      (rsp_count),
      .error_count    (list_errors),
      .pending_count  (results_pending)
   );

   // Drive one command and hold it until the transfer; start stays high afterwards.
   task automatic send_op(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                          input logic [VAL_W-1:0] word);
      start <= 1'b1;
      req_cmd <= cmd;
      req_position <= pos;
      req_item_value <= word;
      do @(posedge clock); while (busy);
   endtask

   task automatic pause_sender(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   function automatic logic [POS_W-1:0] pick_position(input bit low_bias);
      if ($urandom_range(0, 9) == 0) return POS_W'($urandom_range(17, 31));
      // reads and deletes lean toward the front so they hit a short list too
      if (low_bias) return POS_W'($urandom_range(0, $urandom_range(0, 16)));
      return POS_W'($urandom_range(0, 16));
   endfunction

   function automatic logic [VAL_W-1:0] pick_word();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return VAL_W'($urandom);
   endfunction

   task automatic pick_op(input int mode, output logic [CMD_W-1:0] cmd,
                          output logic [POS_W-1:0] pos, output logic [VAL_W-1:0] word);
      int r;
      r = $urandom_range(0, 99);
      case (mode)
         MODE_FILL: begin
            if (r < 55) cmd = OP_APPEND;
            else if (r < 85) cmd = OP_INSERT;
            else if (r < 95) cmd = OP_READ;
            else if (r < 97) cmd = OP_DELETE;
            else if (r < 99) cmd = CMD_W'($urandom_range(FIRST_UNUSED_OP, LAST_UNUSED_OP));
            else cmd = OP_CLEAR;
         end
         MODE_DRAIN: begin
            if (r < 55) cmd = OP_DELETE;
            else if (r < 80) cmd = OP_READ;
            else if (r < 88) cmd = OP_INSERT;
            else if (r < 95) cmd = OP_APPEND;
            else if (r < 98) cmd = OP_CLEAR;
            else cmd = CMD_W'($urandom_range(FIRST_UNUSED_OP, LAST_UNUSED_OP));
         end
         default: begin
            if (r < 22) cmd = OP_APPEND;
            else if (r < 44) cmd = OP_INSERT;
            else if (r < 66) cmd = OP_DELETE;
            else if (r < 90) cmd = OP_READ;
            else if (r < 95) cmd = CMD_W'($urandom_range(FIRST_UNUSED_OP, LAST_UNUSED_OP));
            else cmd = OP_CLEAR;
         end
      endcase
      pos = pick_position(cmd == OP_DELETE || cmd == OP_READ);
      word = pick_word();
   endtask

   // End the run when neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int               mode;
      int               run_left;
      int               burst_left;
      logic [CMD_W-1:0] cmd;
      logic [POS_W-1:0] pos;
      logic [VAL_W-1:0] word;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty list, both ends, out-of-range positions, unused codes, clear
      send_op(OP_READ, 0, 32'h0);
      send_op(OP_DELETE, 0, 32'h0);
      send_op(OP_APPEND, 0, 32'h0000_0000);
      send_op(OP_APPEND, 31, 32'hFFFF_FFFF);
      send_op(OP_APPEND, 0, 32'hA5A5_5A5A);
      send_op(OP_INSERT, 0, 32'h1234_5678);
      send_op(OP_INSERT, 4, 32'h8765_4321);
      send_op(OP_INSERT, 6, 32'hDEAD_BEEF);
      send_op(OP_INSERT, 2, 32'h0F0F_F0F0);
      send_op(OP_READ, 0, 32'h0);
      send_op(OP_READ, 5, 32'h0);
      send_op(OP_READ, 6, 32'h0);
      send_op(OP_READ, 31, 32'h0);
      send_op(OP_DELETE, 5, 32'h0);
      send_op(OP_DELETE, 0, 32'h0);
      send_op(OP_DELETE, 16, 32'h0);
      send_op(OP_DELETE, 31, 32'h0);
      send_op(FIRST_UNUSED_OP, 31, 32'hFFFF_FFFF);
      send_op(MID_UNUSED_OP, 16, 32'h0);
      send_op(LAST_UNUSED_OP, 0, 32'h5555_AAAA);
      send_op(OP_CLEAR, 31, 32'hFFFF_FFFF);
      send_op(OP_READ, 0, 32'h0);
      send_op(OP_INSERT, 0, 32'hC001_D00D);
      send_op(OP_READ, 0, 32'h0);

      // random: runs that fill, drain or mix, sent in bursts, most of them followed by a gap
      run_left = 0;
      mode = MODE_MIXED;
      burst_left = $urandom_range(1, 30);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (run_left == 0) begin
            mode = $urandom_range(MODE_FILL, MODE_MIXED);
            run_left = $urandom_range(20, 60);
         end
         pick_op(mode, cmd, pos, word);
         send_op(cmd, pos, word);
         run_left--;
         burst_left--;
         if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
            burst_left = $urandom_range(1, 30);
         end
      end

      start <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (list_errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
